// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== design/rrqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrqs_pkg
// types and constants shared by the round-robin quantum scheduler
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int         LEN_BITS      = 16;
  localparam logic       FUNC_ADMIT    = 1'b0;
  localparam logic       FUNC_TICK     = 1'b1;
  localparam logic [7:0] QUANTUM_RESET = 8'd5;

  typedef struct packed {
    logic                func;
    logic [LEN_BITS-1:0] length;
  } in_word_t;

  typedef struct packed {
    logic [3:0] slot;
    logic       slot_valid;
    logic       accepted;
    logic       finished;
    logic       idle;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WB   = 2'b10
  } state_t;

endpackage

// ===== design/rrqs_ram.sv =====
// ----------------------------------------------------------------------------
// rrqs_ram
// remaining-tick store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rrqs_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/rrqs_sel.sv =====
// ----------------------------------------------------------------------------
// rrqs_sel
// rotating priority encoder: first set bit after a start position, wrapping,
// with the start position itself checked last
// ----------------------------------------------------------------------------
module rrqs_sel #(
  parameter int SLOTS = 16
) (
  input  logic [SLOTS-1:0]         vec,
  input  logic [$clog2(SLOTS)-1:0] from,
  output logic [$clog2(SLOTS)-1:0] idx,
  output logic                     found
);

  localparam int IDX_W = $clog2(SLOTS);

  logic [IDX_W:0] pos;

  // walk from the far end so the nearest hit is the one that sticks
  always_comb begin
    found = 1'b0;
    idx   = '0;
    pos   = '0;
    for (int k = SLOTS; k >= 1; k--) begin
      pos = (IDX_W+1)'(from) + (IDX_W+1)'(k);
      if (pos >= (IDX_W+1)'(SLOTS)) begin
        pos = pos - (IDX_W+1)'(SLOTS);
      end
      if (vec[pos[IDX_W-1:0]]) begin
        found = 1'b1;
        idx   = pos[IDX_W-1:0];
      end
    end
  end

endmodule

// ===== design/round_robin_quantum_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler: admit result strobed the next cycle
// a tick with a job reads the remaining-tick memory, then writes it back,
// result strobed the cycle after; busy is high during the write-back cycle
// synchronous active-low reset frees all slots; quantum resets to 5
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module round_robin_quantum_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rrqs_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output rrqs_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  import rrqs_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int EXT_W = LEN_BITS + 16;

  state_t               state_r, state_nxt;
  logic [SLOTS-1:0]     occ_r, occ_nxt;
  logic [IDX_W-1:0]     run_slot_r, run_slot_nxt;
  logic                 run_valid_r, run_valid_nxt;
  logic [7:0]           slice_r, slice_nxt;
  logic [7:0]           quantum_r;
  logic [IDX_W-1:0]     cur_r, cur_nxt;
  logic [7:0]           slice_base_r, slice_base_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic                 accept;
  logic                 cur_ok;
  logic [IDX_W-1:0]     tick_cur;
  logic                 tick_has;
  logic [IDX_W-1:0]     run_next_idx;
  logic                 run_next_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 free_found;
  logic [SLOTS-1:0]     occ_wb;
  logic [IDX_W-1:0]     wb_next_idx;
  logic                 wb_next_found;
  logic [EXT_W-1:0]     len_ext;
  logic [IDX_W+3:0]     cur_ext;
  logic [IDX_W+3:0]     free_ext;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [LEN_BITS-1:0]  mem_wdata;
  logic [LEN_BITS-1:0]  mem_rdata;
  logic [LEN_BITS-1:0]  rem_dec;
  logic [7:0]           slice_inc;
  logic [7:0]           q_eff;
  logic                 done;

  assign busy      = (state_r == ST_WB);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  assign len_ext  = EXT_W'(in_word.length);
  assign cur_ext  = (IDX_W+4)'(cur_r);
  assign free_ext = (IDX_W+4)'(free_idx);

  assign cur_ok   = run_valid_r && occ_r[run_slot_r];
  assign tick_cur = cur_ok ? run_slot_r : run_next_idx;
  assign tick_has = cur_ok || run_next_found;

  // next job when the running slot has gone stale
  rrqs_sel #(.SLOTS(SLOTS)) u_sel_run (
    .vec   (occ_r),
    .from  (run_slot_r),
    .idx   (run_next_idx),
    .found (run_next_found)
  );

  // lowest free slot: search the free mask starting just after the top slot
  rrqs_sel #(.SLOTS(SLOTS)) u_sel_free (
    .vec   (~occ_r),
    .from  (IDX_W'(SLOTS - 1)),
    .idx   (free_idx),
    .found (free_found)
  );

  // successor of the job that just ran, with its slot dropped if it finished
  rrqs_sel #(.SLOTS(SLOTS)) u_sel_wb (
    .vec   (occ_wb),
    .from  (cur_r),
    .idx   (wb_next_idx),
    .found (wb_next_found)
  );

  rrqs_ram #(.DEPTH(SLOTS), .WIDTH(LEN_BITS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (tick_cur),
    .rdata (mem_rdata)
  );

  assign rem_dec   = (mem_rdata != '0) ? mem_rdata - LEN_BITS'(1) : '0;
  assign done      = (rem_dec == '0);
  assign slice_inc = (slice_base_r == 8'hFF) ? slice_base_r : slice_base_r + 8'd1;
  assign q_eff     = (quantum_r == 8'd0) ? 8'd1 : quantum_r;

  always_comb begin
    occ_wb = occ_r;
    if (done) begin
      occ_wb[cur_r] = 1'b0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    run_slot_nxt   = run_slot_r;
    run_valid_nxt  = run_valid_r;
    slice_nxt      = slice_r;
    cur_nxt        = cur_r;
    slice_base_nxt = slice_base_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    mem_we         = 1'b0;
    mem_waddr      = free_idx;
    mem_wdata      = len_ext[LEN_BITS-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.func == FUNC_ADMIT) begin
            out_strobe_nxt = 1'b1;
            out_word_nxt   = '0;
            if (free_found) begin
              occ_nxt[free_idx]       = 1'b1;
              mem_we                  = 1'b1;
              out_word_nxt.slot       = free_ext[3:0];
              out_word_nxt.slot_valid = 1'b1;
              out_word_nxt.accepted   = 1'b1;
              if (!run_valid_r) begin
                run_slot_nxt  = free_idx;
                run_valid_nxt = 1'b1;
                slice_nxt     = 8'd0;
              end
            end
          end else if (tick_has) begin
            cur_nxt        = tick_cur;
            slice_base_nxt = cur_ok ? slice_r : 8'd0;
            state_nxt      = ST_WB;
          end else begin
            out_strobe_nxt = 1'b1;
            out_word_nxt   = '0;
            run_valid_nxt  = 1'b0;
            run_slot_nxt   = '0;
            slice_nxt      = 8'd0;
          end
        end
      end
      ST_WB: begin
        // rdata holds the remaining ticks of cur_r, read at the accept edge
        mem_we                  = 1'b1;
        mem_waddr               = cur_r;
        mem_wdata               = rem_dec;
        out_strobe_nxt          = 1'b1;
        out_word_nxt            = '0;
        out_word_nxt.slot       = cur_ext[3:0];
        out_word_nxt.slot_valid = 1'b1;
        state_nxt               = ST_IDLE;
        if (done) begin
          out_word_nxt.finished = 1'b1;
          occ_nxt               = occ_wb;
          run_valid_nxt         = wb_next_found;
          run_slot_nxt          = wb_next_found ? wb_next_idx : '0;
          slice_nxt             = 8'd0;
        end else if (slice_inc >= q_eff) begin
          run_valid_nxt = 1'b1;
          run_slot_nxt  = wb_next_idx;
          slice_nxt     = 8'd0;
        end else begin
          run_valid_nxt = 1'b1;
          run_slot_nxt  = cur_r;
          slice_nxt     = slice_inc;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_strobe_nxt) begin
      out_word_nxt.idle = (occ_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      occ_r        <= '0;
      run_slot_r   <= '0;
      run_valid_r  <= 1'b0;
      slice_r      <= 8'd0;
      quantum_r    <= QUANTUM_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      run_slot_r   <= run_slot_nxt;
      run_valid_r  <= run_valid_nxt;
      slice_r      <= slice_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        quantum_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    slice_base_r <= slice_base_nxt;
    out_word_r   <= out_word_nxt;
  end

  `ASSERT_CLK(a_wb_strobes, (state_r == ST_WB) |=> out_strobe, "write-back gave no word")
  `ASSERT_CLK(a_run_occupied, (state_r == ST_IDLE && run_valid_r) |-> occ_r[run_slot_r],
              "running slot is not occupied")
  `ASSERT_CLK(a_idle_empty, (out_strobe && out_word.idle) |-> (occ_r == '0),
              "idle reported with jobs present")
  `ASSERT_NEVER(a_wb_no_accept, busy && $past(busy), "write-back held longer than one cycle")

endmodule
